FILE: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared sizes, request codes, controller states and the bit search helper.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int BITMAP_WORDS = 1024;
  localparam int WORD_BITS    = 32;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int WORD_AW      = $clog2(BITMAP_WORDS);
  localparam int PAGE_W       = 15;
  localparam int PAGE_WORD_W  = PAGE_W - BIT_W;
  localparam int USABLE_W     = 11;
  localparam int MODE_W       = 2;

  localparam logic [USABLE_W-1:0] USABLE_RESET = USABLE_W'(1024);
  localparam logic [USABLE_W-1:0] USABLE_MAX   = USABLE_W'(BITMAP_WORDS);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_t;

  function automatic logic [BIT_W-1:0] lowest_clear(input word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

FILE: hw/rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// Bitmap word memory
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Clearing pass, next-fit word scan, read-modify-write and result register.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bpa_pkg::USABLE_W-1:0]      usable_words,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [bpa_pkg::MODE_W-1:0]        mode,
  input  logic [bpa_pkg::PAGE_W-1:0]        page_num,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              found,
  output logic [bpa_pkg::PAGE_W-1:0]        alloc_page,
  output logic                              ram_we,
  output logic [bpa_pkg::WORD_AW-1:0]       ram_waddr,
  output bpa_pkg::word_t                    ram_wdata,
  output logic                              ram_re,
  output logic [bpa_pkg::WORD_AW-1:0]       ram_raddr,
  input  bpa_pkg::word_t                    ram_rdata
);

  bpa_pkg::state_t                  state, state_next;
  bpa_pkg::mode_t                   mode_q;
  logic [bpa_pkg::BIT_W-1:0]        bit_q;
  logic                             in_range;
  logic [bpa_pkg::WORD_AW-1:0]      word, word_next;
  logic [bpa_pkg::WORD_AW-1:0]      scan_start;
  logic [bpa_pkg::WORD_AW-1:0]      clr_addr;
  logic [bpa_pkg::USABLE_W-1:0]     cnt;
  logic                             res_found;
  logic [bpa_pkg::PAGE_W-1:0]       res_page;

  logic [bpa_pkg::USABLE_W-1:0]     lim;
  logic [bpa_pkg::USABLE_W-1:0]     word_inc;
  logic [bpa_pkg::WORD_AW-1:0]      start_word;
  logic [bpa_pkg::WORD_AW-1:0]      req_word;
  logic [bpa_pkg::PAGE_WORD_W-1:0]  page_word;
  logic                             accept;
  logic                             slot_free;
  logic                             clr_last;
  logic                             word_full;
  logic [bpa_pkg::BIT_W-1:0]        free_bit;
  logic                             scan_hit;
  logic                             scan_more;
  logic                             eval_found;
  logic [bpa_pkg::PAGE_W-1:0]       eval_page;

  always_comb begin
    if (usable_words == '0) begin
      lim = bpa_pkg::USABLE_W'(1);
    end else if (usable_words > bpa_pkg::USABLE_MAX) begin
      lim = bpa_pkg::USABLE_MAX;
    end else begin
      lim = usable_words;
    end
  end

  assign page_word  = page_num[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
  assign start_word = (bpa_pkg::USABLE_W'(scan_start) >= lim) ? '0 : scan_start;
  assign req_word   = (bpa_pkg::mode_t'(mode) == bpa_pkg::MODE_ALLOC) ? start_word
                    : bpa_pkg::WORD_AW'(page_word);
  assign word_inc   = bpa_pkg::USABLE_W'(word) + bpa_pkg::USABLE_W'(1);
  assign word_next  = (word_inc >= lim) ? '0 : bpa_pkg::WORD_AW'(word_inc);
  assign clr_last   = clr_addr == bpa_pkg::WORD_AW'(bpa_pkg::BITMAP_WORDS - 1);
  assign slot_free  = !rsp_valid || !rsp_stall;
  assign word_full  = ram_rdata == '1;
  assign free_bit   = bpa_pkg::lowest_clear(ram_rdata);
  assign accept     = req_valid && !req_stall;
  assign scan_hit   = (mode_q == bpa_pkg::MODE_ALLOC) && !word_full;
  assign scan_more  = (mode_q == bpa_pkg::MODE_ALLOC) && word_full && (cnt != lim);

  always_comb begin
    state_next = state;
    unique case (state)
      bpa_pkg::ST_CLEAR: if (clr_last) state_next = bpa_pkg::ST_IDLE;
      bpa_pkg::ST_IDLE:  if (accept) state_next = bpa_pkg::ST_EVAL;
      bpa_pkg::ST_EVAL:  if (!scan_more) state_next = bpa_pkg::ST_DONE;
      bpa_pkg::ST_DONE:  if (slot_free) state_next = bpa_pkg::ST_IDLE;
      default:           state_next = bpa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = word;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = req_word;
    eval_found = 1'b0;
    eval_page  = '0;
    unique case (state)
      bpa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '1;
      end
      bpa_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        ram_re    = req_valid;
      end
      bpa_pkg::ST_EVAL: begin
        unique case (mode_q)
          bpa_pkg::MODE_ALLOC: begin
            if (scan_hit) begin
              ram_we     = 1'b1;
              ram_wdata  = ram_rdata | (bpa_pkg::word_t'(1) << free_bit);
              eval_found = 1'b1;
              eval_page  = bpa_pkg::PAGE_W'({word, free_bit});
            end else if (scan_more) begin
              ram_re    = 1'b1;
              ram_raddr = word_next;
            end
          end
          bpa_pkg::MODE_FREE: begin
            ram_we     = in_range;
            ram_wdata  = ram_rdata & ~(bpa_pkg::word_t'(1) << bit_q);
            eval_found = in_range;
          end
          bpa_pkg::MODE_RESERVE: begin
            ram_we     = in_range;
            ram_wdata  = ram_rdata | (bpa_pkg::word_t'(1) << bit_q);
            eval_found = in_range;
          end
          default: begin
            eval_found = 1'b0;
          end
        endcase
      end
      bpa_pkg::ST_DONE: begin
        req_stall = 1'b1;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bpa_pkg::ST_CLEAR;
      clr_addr   <= '0;
      scan_start <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bpa_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + bpa_pkg::WORD_AW'(1);
      end
      if (state == bpa_pkg::ST_EVAL && scan_hit) begin
        scan_start <= word;
      end
      if (state == bpa_pkg::ST_DONE && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= bpa_pkg::mode_t'(mode);
      bit_q    <= page_num[bpa_pkg::BIT_W-1:0];
      in_range <= 32'(page_word) < bpa_pkg::BITMAP_WORDS;
      word     <= req_word;
      cnt      <= bpa_pkg::USABLE_W'(1);
    end else if (state == bpa_pkg::ST_EVAL && scan_more) begin
      word <= word_next;
      cnt  <= cnt + bpa_pkg::USABLE_W'(1);
    end
    if (state == bpa_pkg::ST_EVAL) begin
      res_found <= eval_found;
      res_page  <= eval_page;
    end
    if (state == bpa_pkg::ST_DONE && slot_free) begin
      found      <= res_found;
      alloc_page <= res_page;
    end
  end

endmodule

FILE: hw/rtl/bitmap_page_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Next-fit page allocator over a used-page bitmap held in one RAM.
// ----------------------------------------------------------------------------
// After reset the block sets every bitmap word to all used, one word per
// cycle, and accepts no request meanwhile; the register port is open
// throughout. Requests are then taken one at a time. A free or reserve
// request passes through accept with the word read, modify and write back,
// and the result load. An allocate request reads one bitmap word per cycle
// through the single read port of the bitmap RAM and examines at most the
// usable word count before the result load. A new request is taken while
// an earlier result still waits in the output register.
module bitmap_page_allocator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpa_pkg::USABLE_W-1:0]      usable_words,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [bpa_pkg::MODE_W-1:0]        mode,
  input  logic [bpa_pkg::PAGE_W-1:0]        page_num,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              found,
  output logic [bpa_pkg::PAGE_W-1:0]        alloc_page
);

  logic [bpa_pkg::USABLE_W-1:0] usable_reg;
  logic                         ram_we;
  logic [bpa_pkg::WORD_AW-1:0]  ram_waddr;
  bpa_pkg::word_t               ram_wdata;
  logic                         ram_re;
  logic [bpa_pkg::WORD_AW-1:0]  ram_raddr;
  bpa_pkg::word_t               ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_reg <= bpa_pkg::USABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      usable_reg <= usable_words;
    end
  end

  bpa_ram #(
    .DATA_W (bpa_pkg::WORD_BITS),
    .DEPTH  (bpa_pkg::BITMAP_WORDS),
    .ADDR_W (bpa_pkg::WORD_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .usable_words (usable_reg),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .page_num     (page_num),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .found        (found),
    .alloc_page   (alloc_page),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  a_no_req_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted during the clearing pass");

  a_no_page_without_found: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !found |-> alloc_page == '0)
    else $error("page number reported without a successful allocation");

  a_no_write_on_read_accept: assert property (@(posedge clk) disable iff (rst)
      req_valid && !req_stall |-> !ram_we)
    else $error("bitmap write coincides with a request transaction");

endmodule
